FILE: src/rfb_pkg.sv
// shared types and codes for the reader frame builder
// no dependencies

package rfb_pkg;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    // configuration register indexes
    localparam logic CfgAckByte    = 1'b0;
    localparam logic CfgMaxPayload = 1'b1;

    localparam logic [7:0]  AckByteReset    = 8'd96;
    localparam logic [15:0] MaxPayloadReset = 16'd506;

    typedef enum logic {
        ACTION_START   = 1'b0,
        ACTION_PAYLOAD = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_LONG = 2'd1,
        STATUS_NO_FRAME = 2'd2
    } status_t;

    // what the back end has to do for one accepted item
    typedef enum logic [1:0] {
        KIND_START    = 2'd0,
        KIND_DATA     = 2'd1,
        KIND_TOO_LONG = 2'd2,
        KIND_NO_FRAME = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ack;
        logic [15:0] length;
        logic [7:0]  value;   // command on a start, data byte on payload
        logic        fin;     // lrc byte follows this record
    } rec_t;

    typedef enum logic [2:0] {
        ST_FIRST,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_CMD,
        ST_LRC
    } step_t;

endpackage

FILE: src/rfb_front.sv
// front end: accepts input items, tracks the open frame, classifies items
// depends on rfb_pkg

module rfb_front
    import rfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // command[7:0], length[23:8], data_byte[31:24]
    input  logic        s_tuser,   // action
    input  logic [7:0]  ack_byte,
    input  logic [15:0] max_payload,
    output logic        q_push,
    output rec_t        q_rec,
    input  logic        q_full
);

    logic        frame_open_reg, frame_open_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  command;
    logic [15:0] length;
    logic [7:0]  data_byte;

    assign command   = s_tdata[7:0];
    assign length    = s_tdata[23:8];
    assign data_byte = s_tdata[31:24];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb
    begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        q_rec.kind      = KIND_START;
        q_rec.ack       = ack_byte;
        q_rec.length    = length;
        q_rec.value     = command;
        q_rec.fin       = (length == 16'd0);
        if (action_t'(s_tuser) == ACTION_START)
        begin
            if (length > max_payload)
            begin
                q_rec.kind      = KIND_TOO_LONG;
                frame_open_next = 1'b0;
                bytes_left_next = 16'd0;
            end
            else
            begin
                frame_open_next = (length != 16'd0);
                bytes_left_next = length;
            end
        end
        else
        begin
            q_rec.value = data_byte;
            q_rec.fin   = (bytes_left_reg == 16'd1);
            if (!frame_open_reg)
            begin
                q_rec.kind = KIND_NO_FRAME;
            end
            else
            begin
                q_rec.kind      = KIND_DATA;
                bytes_left_next = bytes_left_reg - 16'd1;
                frame_open_next = (bytes_left_reg != 16'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 16'd0;
        end
        else if (q_push)
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    // an open frame always still expects at least one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_open_reg |-> (bytes_left_reg != 16'd0))
        else $error("frame open with no bytes left");

endmodule

FILE: src/rfb_queue.sv
// short record queue between front and back end
// depends on rfb_pkg

module rfb_queue
    import rfb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t push_rec,
    output logic full,
    input  logic pop,
    output logic valid,
    output rec_t head
);

    rec_t                 mem_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QueuePtrW:0]   count_reg, count_next;

    assign full  = (count_reg == (QueuePtrW+1)'(QueueDepth));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && valid))
            count_next = count_reg + 1'b1;
        else if (!push && pop && valid)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && valid)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QueuePtrW+1)'(QueueDepth))
        else $error("queue count beyond depth");

endmodule

FILE: src/rfb_back.sv
// back end: walks each record through its result bytes, keeps the lrc
// depends on rfb_pkg

module rfb_back
    import rfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  rec_t       q_head,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,
    output logic [2:0] m_tuser    // frame_end[0], status[2:1]
);

    step_t      state_reg, state_next;
    logic [7:0] lrc_reg, lrc_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_end_reg;
    status_t    out_status_reg;

    logic       adv;
    logic       pop_step;
    logic [7:0] emit_byte;
    logic       emit_last;
    logic       emit_end;
    status_t    emit_status;

    assign adv   = q_valid && (!out_valid_reg || m_tready);
    assign q_pop = adv && pop_step;

    // next step of the sequence
    always_comb
    begin
        state_next = state_reg;
        if (adv)
        begin
            case (state_reg)
                ST_FIRST:
                begin
                    if (q_head.kind == KIND_START)
                        state_next = ST_LEN_HI;
                    else if (q_head.kind == KIND_DATA && q_head.fin)
                        state_next = ST_LRC;
                    else
                        state_next = ST_FIRST;
                end
                ST_LEN_HI: state_next = ST_LEN_LO;
                ST_LEN_LO: state_next = ST_CMD;
                ST_CMD:    state_next = q_head.fin ? ST_LRC : ST_FIRST;
                ST_LRC:    state_next = ST_FIRST;
                default:   state_next = ST_FIRST;
            endcase
        end
    end

    // result of the current step
    always_comb
    begin
        emit_byte   = 8'd0;
        emit_last   = 1'b0;
        emit_end    = 1'b0;
        emit_status = STATUS_OK;
        pop_step    = 1'b0;
        lrc_next    = lrc_reg;
        case (state_reg)
            ST_FIRST:
            begin
                case (q_head.kind)
                    KIND_START:
                    begin
                        emit_byte = q_head.ack;
                        lrc_next  = q_head.ack;
                    end
                    KIND_DATA:
                    begin
                        emit_byte = q_head.value;
                        lrc_next  = lrc_reg ^ q_head.value;
                        emit_last = !q_head.fin;
                        pop_step  = !q_head.fin;
                    end
                    KIND_TOO_LONG:
                    begin
                        emit_status = STATUS_TOO_LONG;
                        emit_last   = 1'b1;
                        pop_step    = 1'b1;
                    end
                    default:
                    begin
                        emit_status = STATUS_NO_FRAME;
                        emit_last   = 1'b1;
                        pop_step    = 1'b1;
                    end
                endcase
            end
            ST_LEN_HI:
            begin
                emit_byte = q_head.length[15:8];
                lrc_next  = lrc_reg ^ q_head.length[15:8];
            end
            ST_LEN_LO:
            begin
                emit_byte = q_head.length[7:0];
                lrc_next  = lrc_reg ^ q_head.length[7:0];
            end
            ST_CMD:
            begin
                emit_byte = q_head.value;
                lrc_next  = lrc_reg ^ q_head.value;
                emit_last = !q_head.fin;
                pop_step  = !q_head.fin;
            end
            ST_LRC:
            begin
                emit_byte = lrc_reg;
                emit_last = 1'b1;
                emit_end  = 1'b1;
                pop_step  = 1'b1;
                lrc_next  = 8'd0;
            end
            default:
            begin
                pop_step = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FIRST;
            lrc_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (adv)
            begin
                lrc_reg       <= lrc_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte_reg   <= emit_byte;
            out_last_reg   <= emit_last;
            out_end_reg    <= emit_end;
            out_status_reg <= emit_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_status_reg, out_end_reg};

    // mid-sequence the record must still sit at the queue head
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_FIRST) |-> q_valid)
        else $error("sequence running without a record");

    // the lrc byte always closes the burst
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_end_reg) |-> (out_last_reg && out_status_reg == STATUS_OK))
        else $error("lrc byte not marked last");

    // error results carry a zero byte and end the burst
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != STATUS_OK)
            |-> (out_last_reg && out_byte_reg == 8'd0 && !out_end_reg))
        else $error("malformed error result");

    // a record is only dropped when its final result goes out
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (out_valid_reg && out_last_reg))
        else $error("record popped without a last result");

endmodule

FILE: src/reader_frame_builder_xor_lrc_top.sv
// top level of the reader frame builder with xor lrc
// depends on rfb_pkg, rfb_front, rfb_queue, rfb_back
//
// usage:
//   s_* channel takes one item per accepted beat. s_tuser is the action:
//   0 starts a frame (command and length used), 1 is a payload byte.
//   m_* channel gives the frame bytes. m_tlast marks the final byte caused
//   by one input item, m_tuser[0] marks the closing lrc byte and
//   m_tuser[2:1] is the status (ok, length too long, byte outside frame).
//   cfg_* writes ack_byte (index 0, low 8 bits of cfg_data) or
//   max_payload (index 1); cfg_ready is always high. write only when idle.
// timing:
//   an item's first result passes the record queue and the output register
//   before it shows on m_*. while m_tready is high the back end sends one
//   byte per cycle, so a payload item gives one byte (two with the lrc
//   byte), a start four or five bytes, an error one. the four-deep record
//   queue lets the front keep accepting items while a header burst drains.
// reset and stall:
//   reset closes any frame, clears the lrc and queue, and loads ack_byte
//   96 and max_payload 506. when m_tready is low the output register holds
//   its byte, the queue fills, and s_tready drops once it is full.

module reader_frame_builder_xor_lrc_top
    import rfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // command[7:0], length[23:8], data_byte[31:24]
    input  logic        s_tuser,   // action
    // frame bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,   // last
    output logic [2:0]  m_tuser,   // frame_end[0], status[2:1]
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [7:0]  ack_byte_reg;
    logic [15:0] max_payload_reg;

    logic q_push, q_full, q_pop, q_valid;
    rec_t q_push_rec, q_head;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_byte_reg    <= AckByteReset;
            max_payload_reg <= MaxPayloadReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CfgAckByte)
                ack_byte_reg <= cfg_data[7:0];
            else if (cfg_index == CfgMaxPayload)
                max_payload_reg <= cfg_data;
        end
    end

    // front end: classify items and track frame state
    rfb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .ack_byte    (ack_byte_reg),
        .max_payload (max_payload_reg),
        .q_push      (q_push),
        .q_rec       (q_push_rec),
        .q_full      (q_full)
    );

    // record queue decoupling the two sides
    rfb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (q_push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    // back end: byte sequencer, lrc and output register
    rfb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
